// ===== rtl/llfl_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// llfl_pkg
// Shared types and constants of the linked-list entry pool: pool size,
// field widths, command and status codes, and the port structs.
// ---------------------------------------------------------------------------
package llfl_pkg;

  // pool geometry
  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned LINK_W  = $clog2(ENTRIES + 1);

  // field widths
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned KEY_W  = 64;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned NUM_W  = 5;

  // link value that marks the end of a list
  localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(ENTRIES);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_LIST    = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_WALK,
    S_FREE,
    S_LIST
  } state_e;

  // command payload
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] guest_key;
  } req_t;

  // result payload
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [NUM_W-1:0]  entry_number;
    logic [KEY_W-1:0]  entry_key;
    logic              last;
  } rsp_t;

  // controller to storage
  typedef struct packed {
    logic [IDX_W-1:0]  rd_addr;
    logic              key_we;
    logic              link_we;
    logic [IDX_W-1:0]  wr_addr;
    logic [KEY_W-1:0]  key_wdata;
    logic [LINK_W-1:0] link_wdata;
  } store_req_t;

  // storage read data, registered: valid in the cycle after the address
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [LINK_W-1:0] link;
  } store_rsp_t;

endpackage

// ===== rtl/llfl_store.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// llfl_store
// Key and link memories of the pool. One read address and one write
// address per cycle, read data registered. Link entries not yet written
// read as their reset chain value (next entry, or none for the last one).
// ---------------------------------------------------------------------------
module llfl_store (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  llfl_pkg::store_req_t   req_i,
  output llfl_pkg::store_rsp_t   rsp_o
);

  logic [llfl_pkg::KEY_W-1:0]  key_mem_q  [llfl_pkg::ENTRIES];
  logic [llfl_pkg::LINK_W-1:0] link_mem_q [llfl_pkg::ENTRIES];
  logic [llfl_pkg::ENTRIES-1:0] link_vld_q;

  logic [llfl_pkg::KEY_W-1:0]  key_rd_q;
  logic [llfl_pkg::LINK_W-1:0] link_rd_q;
  logic [llfl_pkg::LINK_W-1:0] link_dflt_q;
  logic                        link_sel_q;

  // key memory
  always_ff @(posedge clk_i) begin
    if (req_i.key_we) begin
      key_mem_q[req_i.wr_addr] <= req_i.key_wdata;
    end
    key_rd_q <= key_mem_q[req_i.rd_addr];
  end

  // link memory
  always_ff @(posedge clk_i) begin
    if (req_i.link_we) begin
      link_mem_q[req_i.wr_addr] <= req_i.link_wdata;
    end
    link_rd_q   <= link_mem_q[req_i.rd_addr];
    link_sel_q  <= link_vld_q[req_i.rd_addr];
    link_dflt_q <= llfl_pkg::LINK_W'(req_i.rd_addr) + llfl_pkg::LINK_W'(1);
  end

  // written marks for the link entries, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q <= '0;
    end else if (req_i.link_we) begin
      link_vld_q[req_i.wr_addr] <= 1'b1;
    end
  end

  assign rsp_o.key  = key_rd_q;
  assign rsp_o.link = link_sel_q ? link_rd_q : link_dflt_q;

endmodule

// ===== rtl/llfl_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// llfl_ctrl
// Command sequencer: holds the list heads, walks the occupied list one
// memory read per cycle and issues the read-modify-write of the links.
// ---------------------------------------------------------------------------
module llfl_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  llfl_pkg::req_t         req_i,
  output logic                   busy_o,
  output llfl_pkg::store_req_t   store_o,
  input  llfl_pkg::store_rsp_t   store_i,
  output logic                   res_valid_o,
  output llfl_pkg::rsp_t         res_o
);

  llfl_pkg::state_e            state_q, state_d;
  logic [llfl_pkg::LINK_W-1:0] free_q, free_d;
  logic [llfl_pkg::LINK_W-1:0] occ_q, occ_d;
  logic [llfl_pkg::LINK_W-1:0] cur_q, cur_d;
  logic [llfl_pkg::LINK_W-1:0] prev_q, prev_d;
  logic [llfl_pkg::LINK_W-1:0] cnt_q, cnt_d;
  logic [llfl_pkg::KEY_W-1:0]  key_q, key_d;

  logic [llfl_pkg::LINK_W-1:0] cnt_inc;
  logic [llfl_pkg::NUM_W-1:0]  cur_num;
  logic                        walk_end;

  assign cnt_inc  = cnt_q + llfl_pkg::LINK_W'(1);
  assign cur_num  = llfl_pkg::NUM_W'({1'b0, cur_q} + (llfl_pkg::LINK_W + 1)'(1));
  assign walk_end = (store_i.link == llfl_pkg::NONE_LINK) ||
                    (cnt_inc == llfl_pkg::LINK_W'(llfl_pkg::ENTRIES));
  assign busy_o   = (state_q != llfl_pkg::S_IDLE);

  // state and list heads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= llfl_pkg::S_IDLE;
      free_q  <= '0;
      occ_q   <= llfl_pkg::NONE_LINK;
      cur_q   <= llfl_pkg::NONE_LINK;
      prev_q  <= llfl_pkg::NONE_LINK;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      occ_q   <= occ_d;
      cur_q   <= cur_d;
      prev_q  <= prev_d;
      cnt_q   <= cnt_d;
    end
  end

  // command key, payload only
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  // next state, memory accesses and results
  always_comb begin
    state_d = state_q;
    free_d  = free_q;
    occ_d   = occ_q;
    cur_d   = cur_q;
    prev_d  = prev_q;
    cnt_d   = cnt_q;
    key_d   = key_q;

    store_o            = '0;
    store_o.rd_addr    = cur_q[llfl_pkg::IDX_W-1:0];
    store_o.wr_addr    = cur_q[llfl_pkg::IDX_W-1:0];
    store_o.key_wdata  = key_q;
    store_o.link_wdata = occ_q;

    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.last  = 1'b1;

    case (state_q)
      llfl_pkg::S_IDLE: begin
        if (start_i) begin
          key_d  = req_i.guest_key;
          cnt_d  = '0;
          prev_d = llfl_pkg::NONE_LINK;
          case (req_i.cmd)
            llfl_pkg::CMD_ALLOC: begin
              if (free_q == llfl_pkg::NONE_LINK) begin
                res_valid_o  = 1'b1;
                res_o.status = llfl_pkg::STAT_FULL;
              end else begin
                store_o.rd_addr = free_q[llfl_pkg::IDX_W-1:0];
                cur_d           = free_q;
                state_d         = llfl_pkg::S_ALLOC;
              end
            end
            llfl_pkg::CMD_RELEASE: begin
              store_o.rd_addr = occ_q[llfl_pkg::IDX_W-1:0];
              cur_d           = occ_q;
              state_d         = llfl_pkg::S_WALK;
            end
            llfl_pkg::CMD_LIST: begin
              store_o.rd_addr = occ_q[llfl_pkg::IDX_W-1:0];
              cur_d           = occ_q;
              state_d         = llfl_pkg::S_LIST;
            end
            default: begin
            end
          endcase
        end
      end

      // pop free head, store key, push onto occupied head
      llfl_pkg::S_ALLOC: begin
        free_d             = store_i.link;
        store_o.key_we     = 1'b1;
        store_o.link_we    = 1'b1;
        store_o.link_wdata = occ_q;
        occ_d              = cur_q;
        res_valid_o        = 1'b1;
        res_o.status       = llfl_pkg::STAT_OK;
        res_o.entry_number = cur_num;
        res_o.entry_key    = key_q;
        state_d            = llfl_pkg::S_IDLE;
      end

      // compare one occupied entry per cycle
      llfl_pkg::S_WALK: begin
        if (cur_q == llfl_pkg::NONE_LINK) begin
          res_valid_o  = 1'b1;
          res_o.status = llfl_pkg::STAT_NOT_FOUND;
          state_d      = llfl_pkg::S_IDLE;
        end else if (store_i.key == key_q) begin
          if (prev_q != llfl_pkg::NONE_LINK) begin
            store_o.link_we    = 1'b1;
            store_o.wr_addr    = prev_q[llfl_pkg::IDX_W-1:0];
            store_o.link_wdata = store_i.link;
          end else begin
            occ_d = store_i.link;
          end
          res_valid_o        = 1'b1;
          res_o.status       = llfl_pkg::STAT_OK;
          res_o.entry_number = cur_num;
          res_o.entry_key    = store_i.key;
          state_d            = llfl_pkg::S_FREE;
        end else if (walk_end) begin
          res_valid_o  = 1'b1;
          res_o.status = llfl_pkg::STAT_NOT_FOUND;
          state_d      = llfl_pkg::S_IDLE;
        end else begin
          store_o.rd_addr = store_i.link[llfl_pkg::IDX_W-1:0];
          prev_d          = cur_q;
          cur_d           = store_i.link;
          cnt_d           = cnt_inc;
        end
      end

      // push released entry onto free head
      llfl_pkg::S_FREE: begin
        store_o.link_we    = 1'b1;
        store_o.link_wdata = free_q;
        free_d             = cur_q;
        state_d            = llfl_pkg::S_IDLE;
      end

      // one listed entry per cycle
      llfl_pkg::S_LIST: begin
        res_valid_o = 1'b1;
        if (cur_q == llfl_pkg::NONE_LINK) begin
          res_o.status = llfl_pkg::STAT_EMPTY;
          state_d      = llfl_pkg::S_IDLE;
        end else begin
          res_o.status       = llfl_pkg::STAT_OK;
          res_o.entry_number = cur_num;
          res_o.entry_key    = store_i.key;
          res_o.last         = walk_end;
          if (walk_end) begin
            state_d = llfl_pkg::S_IDLE;
          end else begin
            store_o.rd_addr = store_i.link[llfl_pkg::IDX_W-1:0];
            cur_d           = store_i.link;
            cnt_d           = cnt_inc;
          end
        end
      end

      default: begin
        state_d = llfl_pkg::S_IDLE;
      end
    endcase
  end

  // release push only follows a matching walk step
  a_free_after_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == llfl_pkg::S_FREE) |-> ($past(state_q) == llfl_pkg::S_WALK))
    else $error("release push without preceding walk");

  // heads of the two lists never name the same entry
  a_heads_apart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_q == occ_q) |-> (free_q == llfl_pkg::NONE_LINK))
    else $error("free and occupied heads coincide");

  // walk step count stays below the pool size
  a_walk_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == llfl_pkg::S_WALK) || (state_q == llfl_pkg::S_LIST)) |->
    (cnt_q < llfl_pkg::LINK_W'(llfl_pkg::ENTRIES)))
    else $error("walk ran past the pool size");

  // a single-result command ends in the cycle of its result
  a_single_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (state_q != llfl_pkg::S_LIST) && (state_q != llfl_pkg::S_WALK))
    |=> (state_q == llfl_pkg::S_IDLE))
    else $error("sequencer busy after final result");

  // memory writes happen only in update states
  a_write_states : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (store_o.link_we || store_o.key_we) |->
    ((state_q == llfl_pkg::S_ALLOC) || (state_q == llfl_pkg::S_WALK) ||
     (state_q == llfl_pkg::S_FREE)))
    else $error("memory write outside an update state");

endmodule

// ===== rtl/linked_list_free_list_table.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// linked_list_free_list_table
// Fixed pool of keyed entries kept as a free list and an occupied list.
//
// Commands are transferred on req (cmd, guest_key) at a clock edge with
// start high and busy low. Allocate pops the free head and pushes it onto
// the occupied head; release walks the occupied list and frees the first
// entry with a matching key; list gives every occupied entry from the head.
// Results leave on rsp, each valid for exactly one cycle while rsp_valid_o
// is high; the receiver takes every one and cannot stall the block.
// Allocate answers from the idle state when the pool is full, else from
// the allocate state; every result goes through the result register.
// Release answers once its walk hits a match or the end of the list, and
// passes through the free state when an entry is freed. List gives one
// result per cycle from the head. One command is in work at a time; a
// walk costs one key/link memory read per cycle.
// Reset: all entries free in index order, occupied list empty, no results.
// ---------------------------------------------------------------------------
module linked_list_free_list_table (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  llfl_pkg::req_t   req_i,
  output logic             busy,
  output logic             rsp_valid_o,
  output llfl_pkg::rsp_t   rsp_o
);

  llfl_pkg::store_req_t store_req;
  llfl_pkg::store_rsp_t store_rsp;
  logic                 res_valid;
  llfl_pkg::rsp_t       res;

  logic                 rsp_valid_q;
  llfl_pkg::rsp_t       rsp_q;

  // command sequencer
  llfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req_i),
    .busy_o      (busy),
    .store_o     (store_req),
    .store_i     (store_rsp),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // key and link memories
  llfl_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (store_req),
    .rsp_o  (store_rsp)
  );

  // result register, one transfer per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      rsp_q <= res;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== tb/tb_linked_list_free_list_table.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_linked_list_free_list_table
// Self-checking bench for the keyed entry pool with free and occupied lists.
//
// A driver sends allocate, release and list commands from a queue that is
// filled up front. It puts random idle gaps between transfers, and once in a
// while it waits until every due result has arrived. A shadow copy of the
// pool works out the results of each accepted command. A monitor compares
// every result strobe, field by field, with the oldest result still due.
// The directed opening fills the pool, overflows it and releases at the
// head, the tail, the middle and on a duplicate key. Random traffic then
// swings the pool between empty and full.
// ---------------------------------------------------------------------------
module tb_linked_list_free_list_table;

  // command code that the block must ignore
  localparam logic [llfl_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 225;

  typedef struct {
    llfl_pkg::req_t req;
    int unsigned    gap;
    bit             drain;
  } stim_t;

  logic           clk_i  = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start  = 1'b0;
  llfl_pkg::req_t req_i  = '0;
  logic           busy;
  logic           rsp_valid_o;
  llfl_pkg::rsp_t rsp_o;

  // pending commands and results still owed by the block
  stim_t          stim_q[$];
  llfl_pkg::rsp_t due_results[$];

  // shadow copy of the pool
  logic [llfl_pkg::KEY_W-1:0]  pool_key  [llfl_pkg::ENTRIES];
  logic [llfl_pkg::LINK_W-1:0] pool_link [llfl_pkg::ENTRIES];
  logic [llfl_pkg::LINK_W-1:0] free_top;
  logic [llfl_pkg::LINK_W-1:0] used_top;

  // keys that the stimulus believes are held, as a multiset
  logic [llfl_pkg::KEY_W-1:0]  live_keys[$];

  int unsigned fail_count   = 0;
  int unsigned idle_left    = 0;
  int unsigned n_alloc      = 0;
  int unsigned n_full       = 0;
  int unsigned n_release    = 0;
  int unsigned n_missing    = 0;
  int unsigned n_list       = 0;
  int unsigned n_checked    = 0;

  logic           slot_free;
  logic           launch;
  stim_t          next_item;
  llfl_pkg::rsp_t want;

  linked_list_free_list_table uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_i       (req_i),
    .busy        (busy),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(string what, logic [llfl_pkg::KEY_W-1:0] got,
                                 logic [llfl_pkg::KEY_W-1:0] exp_val);
    if (fail_count < 40) begin
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, exp_val);
    end
    fail_count++;
  endtask

  // pool reset: all entries free in index order, nothing occupied
  function automatic void reset_pool();
    for (int i = 0; i < llfl_pkg::ENTRIES; i++) begin
      pool_key[i]  = '0;
      pool_link[i] = llfl_pkg::LINK_W'(i + 1);
    end
    free_top = '0;
    used_top = llfl_pkg::NONE_LINK;
  endfunction

  function automatic llfl_pkg::rsp_t make_result(llfl_pkg::status_e st,
                                                 logic [llfl_pkg::LINK_W-1:0] idx,
                                                 logic [llfl_pkg::KEY_W-1:0] k,
                                                 logic fin);
    llfl_pkg::rsp_t r;
    r.status       = st;
    r.entry_number = (st == llfl_pkg::STAT_OK) ? llfl_pkg::NUM_W'(idx + 1) : '0;
    r.entry_key    = (st == llfl_pkg::STAT_OK) ? k : '0;
    r.last         = fin;
    return r;
  endfunction

  // works out the results of one accepted command and updates the pool
  function automatic void apply_pool_command(llfl_pkg::req_t r);
    logic [llfl_pkg::LINK_W-1:0] cur;
    logic [llfl_pkg::LINK_W-1:0] prev;
    logic [llfl_pkg::LINK_W-1:0] nxt;
    int unsigned                 steps;
    bit                          hit;
    hit   = 1'b0;
    steps = 0;
    case (r.cmd)
      llfl_pkg::CMD_ALLOC: begin
        n_alloc++;
        if (free_top >= llfl_pkg::ENTRIES) begin
          n_full++;
          due_results.push_back(make_result(llfl_pkg::STAT_FULL, '0, '0, 1'b1));
        end else begin
          cur           = free_top;
          free_top      = pool_link[cur];
          pool_key[cur] = r.guest_key;
          pool_link[cur] = used_top;
          used_top      = cur;
          due_results.push_back(make_result(llfl_pkg::STAT_OK, cur, r.guest_key, 1'b1));
        end
      end
      llfl_pkg::CMD_RELEASE: begin
        n_release++;
        prev = llfl_pkg::NONE_LINK;
        cur  = used_top;
        // first match from the head wins
        while (!hit && cur < llfl_pkg::ENTRIES && steps < llfl_pkg::ENTRIES) begin
          if (pool_key[cur] == r.guest_key) begin
            hit = 1'b1;
            if (prev < llfl_pkg::ENTRIES) pool_link[prev] = pool_link[cur];
            else used_top = pool_link[cur];
            pool_link[cur] = free_top;
            free_top       = cur;
            due_results.push_back(make_result(llfl_pkg::STAT_OK, cur, pool_key[cur],
                                              1'b1));
          end else begin
            prev = cur;
            cur  = pool_link[cur];
            steps++;
          end
        end
        if (!hit) begin
          n_missing++;
          due_results.push_back(make_result(llfl_pkg::STAT_NOT_FOUND, '0, '0, 1'b1));
        end
      end
      llfl_pkg::CMD_LIST: begin
        n_list++;
        cur = used_top;
        if (cur >= llfl_pkg::ENTRIES) begin
          due_results.push_back(make_result(llfl_pkg::STAT_EMPTY, '0, '0, 1'b1));
        end else begin
          while (cur < llfl_pkg::ENTRIES && steps < llfl_pkg::ENTRIES) begin
            nxt = pool_link[cur];
            due_results.push_back(make_result(llfl_pkg::STAT_OK, cur, pool_key[cur],
                                              nxt >= llfl_pkg::ENTRIES ||
                                              steps + 1 >= llfl_pkg::ENTRIES));
            steps++;
            cur = nxt;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int unsigned pick_gap(bit no_gaps);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [llfl_pkg::KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return llfl_pkg::KEY_W'($urandom_range(0, 7));
    if (r == 4) return '1;
    return {$urandom, $urandom};
  endfunction

  // queues one command and keeps the multiset of held keys in step
  function automatic void add_item(logic [llfl_pkg::CMD_W-1:0] c,
                                   logic [llfl_pkg::KEY_W-1:0] k,
                                   bit no_gaps, bit drain);
    stim_t s;
    int    pos[$];
    s.req.cmd       = c;
    s.req.guest_key = k;
    s.gap           = pick_gap(no_gaps);
    s.drain         = drain;
    stim_q.push_back(s);
    if (c == llfl_pkg::CMD_ALLOC && live_keys.size() < llfl_pkg::ENTRIES) begin
      live_keys.push_back(k);
    end else if (c == llfl_pkg::CMD_RELEASE) begin
      pos = live_keys.find_first_index(x) with (x == k);
      if (pos.size() > 0) live_keys.delete(pos[0]);
    end
  endfunction

  // driver: one transfer per start/busy handshake
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start     <= 1'b0;
      req_i     <= '0;
      idle_left  = 0;
    end else begin
      slot_free = !start || !busy;
      if (start && !busy) apply_pool_command(req_i);
      launch = 1'b0;
      if (slot_free && stim_q.size() > 0) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (!stim_q[0].drain || (due_results.size() == 0 && !busy)) begin
          launch = 1'b1;
        end
      end
      if (launch) begin
        next_item = stim_q.pop_front();
        req_i    <= next_item.req;
        idle_left = (stim_q.size() > 0) ? stim_q[0].gap : 0;
      end
      if (slot_free) start <= launch;
    end
  end

  // monitor: every strobe must match the oldest result due
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with nothing due, entry",
                        llfl_pkg::KEY_W'(rsp_o.entry_number), '0);
      end else begin
        want = due_results.pop_front();
        n_checked++;
        if (rsp_o.status !== want.status)
          report_mismatch("status", llfl_pkg::KEY_W'(rsp_o.status),
                          llfl_pkg::KEY_W'(want.status));
        if (rsp_o.entry_number !== want.entry_number)
          report_mismatch("entry_number", llfl_pkg::KEY_W'(rsp_o.entry_number),
                          llfl_pkg::KEY_W'(want.entry_number));
        if (rsp_o.entry_key !== want.entry_key)
          report_mismatch("entry_key", rsp_o.entry_key, want.entry_key);
        if (rsp_o.last !== want.last)
          report_mismatch("last", llfl_pkg::KEY_W'(rsp_o.last),
                          llfl_pkg::KEY_W'(want.last));
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    logic [llfl_pkg::KEY_W-1:0] dup_key;
    logic [llfl_pkg::KEY_W-1:0] top_key;
    logic [llfl_pkg::KEY_W-1:0] k;
    int unsigned                n;
    int unsigned                r;
    bit                         filling;
    bit                         no_gaps;
    bit                         drain;

    reset_pool();
    dup_key = 64'hA5A5_5A5A_C3C3_3C3C;
    top_key = {$urandom, $urandom};

    // directed: empty pool, ignored code, fill to overflow, targeted releases
    add_item(llfl_pkg::CMD_LIST, '0, 1'b0, 1'b0);
    add_item(llfl_pkg::CMD_RELEASE, 64'h0000_0000_0000_1234, 1'b0, 1'b0);
    add_item(CMD_UNUSED, '1, 1'b0, 1'b0);
    for (int i = 0; i < llfl_pkg::ENTRIES; i++) begin
      if (i == 0) k = '0;
      else if (i == 1) k = '1;
      else if (i == 5 || i == 9) k = dup_key;
      else if (i == llfl_pkg::ENTRIES - 1) k = top_key;
      else k = {$urandom, $urandom};
      add_item(llfl_pkg::CMD_ALLOC, k, i < 8, 1'b0);
    end
    add_item(llfl_pkg::CMD_ALLOC, {$urandom, $urandom}, 1'b0, 1'b0);
    add_item(llfl_pkg::CMD_LIST, '0, 1'b0, 1'b1);
    add_item(llfl_pkg::CMD_RELEASE, '1, 1'b0, 1'b0);
    add_item(llfl_pkg::CMD_RELEASE, dup_key, 1'b0, 1'b0);
    add_item(llfl_pkg::CMD_RELEASE, top_key, 1'b0, 1'b0);
    add_item(llfl_pkg::CMD_RELEASE, '0, 1'b0, 1'b0);
    add_item(llfl_pkg::CMD_RELEASE, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0);
    add_item(llfl_pkg::CMD_LIST, '0, 1'b0, 1'b0);

    // random: swing between filling and draining the pool
    n       = 0;
    filling = 1'b1;
    no_gaps = 1'b0;
    while (n < RANDOM_ITEMS) begin
      if (n % 30 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      if (live_keys.size() == llfl_pkg::ENTRIES && $urandom_range(0, 3) == 0)
        filling = 1'b0;
      if (live_keys.size() == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
      drain = (n % 50 == 25);
      r = $urandom_range(0, 99);
      if (r < 4) begin
        // noise: ignored code, not counted
        add_item(CMD_UNUSED, {$urandom, $urandom}, no_gaps, 1'b0);
      end else begin
        if (r < 14) begin
          add_item(llfl_pkg::CMD_LIST, {$urandom, $urandom}, no_gaps, drain);
        end else if (filling ? (r < 70) : (r < 34)) begin
          add_item(llfl_pkg::CMD_ALLOC, pick_key(), no_gaps, drain);
        end else begin
          if (live_keys.size() > 0 && $urandom_range(0, 4) != 0)
            k = live_keys[$urandom_range(0, live_keys.size() - 1)];
          else
            k = pick_key();
          add_item(llfl_pkg::CMD_RELEASE, k, no_gaps, drain);
        end
        n++;
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for every transfer, then for the results and a short settle
    while (stim_q.size() > 0 || start) @(posedge clk_i);
    while (due_results.size() > 0) @(posedge clk_i);
    repeat (llfl_pkg::ENTRIES + 8) @(posedge clk_i);

    if (due_results.size() != 0)
      report_mismatch("results never delivered",
                      llfl_pkg::KEY_W'(due_results.size()), '0);

    $display("covered %0d allocates (%0d on a full pool), %0d releases (%0d unmatched)",
             n_alloc, n_full, n_release, n_missing);
    $display("and %0d lists; %0d results checked, %0d mismatches",
             n_list, n_checked, fail_count);
    if (fail_count == 0) begin
      $display("tb_linked_list_free_list_table OK");
    end else begin
      $display("tb_linked_list_free_list_table NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timeout waiting for the block");
    $display("tb_linked_list_free_list_table NOT OK");
    $finish;
  end

endmodule
